### rtl/rle8_pkg.sv
// Package for the 8-bit run-length scanline decoder.
// Holds the command type passed from the parser to the sample scaler, and the status codes.
// No dependencies.
package rle8_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned COUNT_W  = 7;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned PROD_W   = CFG_W + BYTE_W;
	localparam int unsigned QBIT_W   = $clog2(BYTE_W);

	localparam logic [CFG_W-1:0] LINE_WIDTH_RST = 16'd512;
	localparam logic [CFG_W-1:0] PIXEL_MIN_RST  = 16'd0;
	localparam logic [CFG_W-1:0] PIXEL_MAX_RST  = 16'd255;
	localparam logic [CFG_W-1:0] FULL_SCALE     = 16'd255;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_WIDTH = 2'd0,
		REG_PIXEL_MIN  = 2'd1,
		REG_PIXEL_MAX  = 2'd2,
		REG_UNUSED     = 2'd3
	} reg_idx_t;

	// End-of-line status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 3'd0,
		ST_LIT_OVERFLOW = 3'd1,
		ST_LIT_TRUNC    = 3'd2,
		ST_RUN_OVERFLOW = 3'd3,
		ST_RUN_NO_VALUE = 3'd4,
		ST_INCOMPLETE   = 3'd5,
		ST_UNUSED_DATA  = 3'd6,
		ST_RESERVED     = 3'd7
	} line_status_t;

	// One command from the parser: a sample run or an end-of-line status.
	typedef struct packed {
		logic                is_status;
		logic [BYTE_W-1:0]   sample;
		logic [COUNT_W-1:0]  count;
		line_status_t        status;
	} cmd_t;

endpackage

### rtl/rle8_in_if.sv
// Input byte channel of the run-length scanline decoder.
// Depends on rle8_pkg for field widths.
interface rle8_in_if;
	import rle8_pkg::*;

	logic               valid;
	logic               ready;
	logic [BYTE_W-1:0]  data_byte;
	logic               final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

### rtl/rle8_out_if.sv
// Result channel of the run-length scanline decoder.
// Depends on rle8_pkg for field widths.
interface rle8_out_if;
	import rle8_pkg::*;

	logic                valid;
	logic                ready;
	logic                result_kind;
	logic [BYTE_W-1:0]   pixel_value;
	logic [COUNT_W-1:0]  repeat_count;
	logic [STATUS_W-1:0] line_status;
	logic                end_of_line;

	modport source (output valid, output result_kind, output pixel_value,
		output repeat_count, output line_status, output end_of_line, input ready);
	modport sink (input valid, input result_kind, input pixel_value,
		input repeat_count, input line_status, input end_of_line, output ready);
endinterface

### rtl/rle8_cfg_if.sv
// Configuration write channel of the run-length scanline decoder.
// Depends on rle8_pkg for index and data widths.
interface rle8_cfg_if;
	import rle8_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

### rtl/rle8_front.sv
// Parser of the run-length decoder: accepts bytes, tracks the line state and
// issues sample and status commands into the command queue. Depends on rle8_pkg.
module rle8_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [rle8_pkg::BYTE_W-1:0] data_byte,
	input  logic                      final_byte,
	input  logic [rle8_pkg::CFG_W-1:0] line_width,
	output logic                      push,
	output rle8_pkg::cmd_t            push_cmd,
	input  logic                      queue_full
);
	import rle8_pkg::*;

	typedef enum logic [4:0] {
		PH_CODE    = 5'b00001,
		PH_LITERAL = 5'b00010,
		PH_RUNVAL  = 5'b00100,
		PH_ENDED   = 5'b01000,
		PH_ERROR   = 5'b10000
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [COUNT_W-1:0]  lit_rem_q, lit_rem_d;
	logic [COUNT_W-1:0]  run_pend_q, run_pend_d;
	logic [CFG_W-1:0]    pix_rem_q, pix_rem_d;
	line_status_t        err_q, err_d;
	logic                pend_q;
	cmd_t                pend_cmd_q;

	logic                accept;
	logic [COUNT_W-1:0]  cnt;
	logic                cnt_over;
	logic                samp_v;
	cmd_t                samp_cmd;
	cmd_t                stat_cmd;
	line_status_t        status;

	// A held status result blocks the input until it enters the queue.
	assign in_ready = !pend_q && !queue_full;
	assign accept   = in_valid && in_ready;
	assign cnt      = data_byte[COUNT_W-1:0];
	assign cnt_over = {{(CFG_W-COUNT_W){1'b0}}, cnt} > pix_rem_q;

	// Next line state for the accepted byte.
	always_comb begin
		phase_d    = phase_q;
		lit_rem_d  = lit_rem_q;
		run_pend_d = run_pend_q;
		pix_rem_d  = pix_rem_q;
		err_d      = err_q;
		samp_v     = 1'b0;
		samp_cmd   = '{is_status: 1'b0, sample: data_byte, count: 7'd1, status: ST_OK};
		case (phase_q)
			PH_CODE: begin
				if (cnt == '0) begin
					phase_d = PH_ENDED;
				end else if (data_byte[BYTE_W-1]) begin
					if (cnt_over) begin
						err_d   = ST_LIT_OVERFLOW;
						phase_d = PH_ERROR;
					end else begin
						pix_rem_d = pix_rem_q - {{(CFG_W-COUNT_W){1'b0}}, cnt};
						lit_rem_d = cnt;
						phase_d   = PH_LITERAL;
					end
				end else begin
					if (cnt_over) begin
						err_d   = ST_RUN_OVERFLOW;
						phase_d = PH_ERROR;
					end else begin
						run_pend_d = cnt;
						phase_d    = PH_RUNVAL;
					end
				end
			end
			PH_LITERAL: begin
				samp_v    = 1'b1;
				lit_rem_d = lit_rem_q - 7'd1;
				if (lit_rem_d == '0) begin
					phase_d = PH_CODE;
				end
			end
			PH_RUNVAL: begin
				samp_v         = 1'b1;
				samp_cmd.count = run_pend_q;
				if ({{(CFG_W-COUNT_W){1'b0}}, run_pend_q} > pix_rem_q) begin
					pix_rem_d = '0;
				end else begin
					pix_rem_d = pix_rem_q - {{(CFG_W-COUNT_W){1'b0}}, run_pend_q};
				end
				run_pend_d = '0;
				phase_d    = PH_CODE;
			end
			PH_ENDED: begin
				err_d   = (pix_rem_q != '0) ? ST_INCOMPLETE : ST_UNUSED_DATA;
				phase_d = PH_ERROR;
			end
			default: begin
			end
		endcase
	end

	// Status of the line as it stands after this byte.
	always_comb begin
		case (phase_d)
			PH_ERROR:   status = err_d;
			PH_LITERAL: status = ST_LIT_TRUNC;
			PH_RUNVAL:  status = ST_RUN_NO_VALUE;
			default:    status = (pix_rem_d != '0) ? ST_INCOMPLETE : ST_OK;
		endcase
		stat_cmd = '{is_status: 1'b1, sample: '0, count: '0, status: status};
	end

	// Queue write: a held status first, else the command of this byte.
	always_comb begin
		push     = 1'b0;
		push_cmd = stat_cmd;
		if (pend_q) begin
			push     = !queue_full;
			push_cmd = pend_cmd_q;
		end else if (accept) begin
			push     = samp_v || final_byte;
			push_cmd = samp_v ? samp_cmd : stat_cmd;
		end
	end

	// Line state registers; the final byte restarts the line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_CODE;
			lit_rem_q  <= '0;
			run_pend_q <= '0;
			pix_rem_q  <= LINE_WIDTH_RST;
			err_q      <= ST_OK;
			pend_q     <= 1'b0;
		end else begin
			if (pend_q && !queue_full) begin
				pend_q <= 1'b0;
			end
			if (accept) begin
				if (final_byte) begin
					phase_q    <= PH_CODE;
					lit_rem_q  <= '0;
					run_pend_q <= '0;
					pix_rem_q  <= line_width;
					err_q      <= ST_OK;
					pend_q     <= samp_v;
				end else begin
					phase_q    <= phase_d;
					lit_rem_q  <= lit_rem_d;
					run_pend_q <= run_pend_d;
					pix_rem_q  <= pix_rem_d;
					err_q      <= err_d;
				end
			end
		end
	end

	// Held status command payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			pend_cmd_q <= stat_cmd;
		end
	end

endmodule

### rtl/rle8_fifo.sv
// Short command queue between the parser and the sample scaler.
// Depends on rle8_pkg for the command type and depth.
module rle8_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rle8_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output rle8_pkg::cmd_t pop_cmd,
	output logic           empty
);
	import rle8_pkg::*;

	cmd_t                   mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   fill_q;

	assign full    = (fill_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
	assign empty   = (fill_q == '0);
	assign pop_cmd = mem_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

### rtl/rle8_back.sv
// Sample scaler of the run-length decoder: takes commands from the queue,
// clamps and rescales samples with a bit-serial divider, and drives the
// registered result channel. Depends on rle8_pkg.
module rle8_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [rle8_pkg::CFG_W-1:0]  pixel_min,
	input  logic [rle8_pkg::CFG_W-1:0]  pixel_max,
	input  logic                        empty,
	input  rle8_pkg::cmd_t              pop_cmd,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        result_kind,
	output logic [rle8_pkg::BYTE_W-1:0]   pixel_value,
	output logic [rle8_pkg::COUNT_W-1:0]  repeat_count,
	output logic [rle8_pkg::STATUS_W-1:0] line_status,
	output logic                        end_of_line
);
	import rle8_pkg::*;

	typedef enum logic [3:0] {
		BK_IDLE = 4'b0001,
		BK_CALC = 4'b0010,
		BK_DIV  = 4'b0100,
		BK_DONE = 4'b1000
	} back_state_t;

	back_state_t         state_q;
	cmd_t                cmd_q;
	logic [PROD_W-1:0]   rem_q;
	logic [CFG_W-1:0]    span_q;
	logic [QBIT_W-1:0]   bit_q;
	logic [BYTE_W-1:0]   quot_q;

	logic                out_valid_q;
	logic                kind_q;
	logic [BYTE_W-1:0]   pix_q;
	logic [COUNT_W-1:0]  rep_q;
	logic [STATUS_W-1:0] stat_q;
	logic                eol_q;

	logic [CFG_W-1:0]    span;
	logic [CFG_W-1:0]    samp;
	logic [CFG_W-1:0]    clamped;
	logic [PROD_W-1:0]   prod;
	logic [PROD_W:0]     trial;
	logic                out_free;

	assign pop          = (state_q == BK_IDLE) && !empty;
	assign out_free     = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign result_kind  = kind_q;
	assign pixel_value  = pix_q;
	assign repeat_count = rep_q;
	assign line_status  = stat_q;
	assign end_of_line  = eol_q;

	// Clamp into the valid range and multiply by full scale.
	always_comb begin
		span = pixel_max - pixel_min;
		samp = {{(CFG_W-BYTE_W){1'b0}}, cmd_q.sample};
		if (samp < pixel_min) begin
			clamped = '0;
		end else if (samp > pixel_max) begin
			clamped = span;
		end else begin
			clamped = samp - pixel_min;
		end
		prod = {clamped, {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, clamped};
	end

	// One quotient bit per cycle, most significant first.
	assign trial = {1'b0, rem_q} - ({{(BYTE_W+1){1'b0}}, span_q} << bit_q);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// Result register: set when a command finishes, cleared once taken.
			if (state_q == BK_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				BK_IDLE: begin
					if (!empty) begin
						state_q <= pop_cmd.is_status ? BK_DONE : BK_CALC;
					end
				end
				BK_CALC: begin
					if ((pixel_min == '0 && pixel_max == FULL_SCALE) ||
						(pixel_max <= pixel_min)) begin
						state_q <= BK_DONE;
					end else begin
						state_q <= BK_DIV;
					end
				end
				BK_DIV: begin
					if (bit_q == '0) begin
						state_q <= BK_DONE;
					end
				end
				BK_DONE: begin
					if (out_free) begin
						state_q <= BK_IDLE;
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (!empty) begin
					cmd_q  <= pop_cmd;
					quot_q <= '0;
				end
			end
			BK_CALC: begin
				if (pixel_min == '0 && pixel_max == FULL_SCALE) begin
					quot_q <= cmd_q.sample;
				end else if (pixel_max <= pixel_min) begin
					quot_q <= '0;
				end else begin
					rem_q  <= prod;
					span_q <= span;
					bit_q  <= QBIT_W'(BYTE_W - 1);
					quot_q <= '0;
				end
			end
			BK_DIV: begin
				if (!trial[PROD_W]) begin
					rem_q         <= trial[PROD_W-1:0];
					quot_q[bit_q] <= 1'b1;
				end
				bit_q <= bit_q - 1'b1;
			end
			BK_DONE: begin
				if (out_free) begin
					kind_q <= cmd_q.is_status;
					eol_q  <= cmd_q.is_status;
					pix_q  <= cmd_q.is_status ? '0 : quot_q;
					rep_q  <= cmd_q.is_status ? '0 : cmd_q.count;
					stat_q <= cmd_q.is_status ? cmd_q.status : ST_OK;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### rtl/rle8_scanline_decoder_8bit_top.sv
// Top level of the 8-bit run-length scanline decoder: configuration registers,
// parser, command queue and sample scaler. Depends on rle8_pkg and the channel interfaces.
//
// Usage:
// in_ch carries one compressed byte per transfer (data_byte) and final_byte,
// which marks the last byte of a scanline. out_ch carries results: sample runs
// (result_kind 0, pixel_value, repeat_count) and one end-of-line status result
// (result_kind 1, line_status, end_of_line 1) after each final byte.
// cfg writes line_width (index 0), pixel_min (1) and pixel_max (2); it is always
// ready and must be used only while the block is idle. line_width takes effect
// at the next line start.
// Throughput: the parser takes one byte per cycle into a four-entry command queue
// while the queue is not full and no status is held; a final byte that also yields
// a sample holds the input until its held status enters the queue. The scaler takes
// one command at a time; a rescaled sample goes through its bit-serial divider,
// which forms one quotient bit per cycle, while a status result or a sample in
// pass-through or degenerate range skips it. Results reach out_ch from the result register.
// Reset restores line_width 512, pixel_min 0, pixel_max 255 and an empty line.
// When out_ch stalls, the result register holds, the scaler waits, the queue
// fills and in_ch ready then drops; nothing is lost.
module rle_scanline_decoder_8bit_top (
	input  logic        clk,
	input  logic        arst_n,
	rle8_in_if.sink     in_ch,
	rle8_out_if.source  out_ch,
	rle8_cfg_if.sink    cfg
);
	import rle8_pkg::*;

	logic [CFG_W-1:0] line_width_q;
	logic [CFG_W-1:0] pixel_min_q;
	logic [CFG_W-1:0] pixel_max_q;

	logic push;
	cmd_t push_cmd;
	logic queue_full;
	logic pop;
	cmd_t pop_cmd;
	logic queue_empty;

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RST;
			pixel_min_q  <= PIXEL_MIN_RST;
			pixel_max_q  <= PIXEL_MAX_RST;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_LINE_WIDTH: line_width_q <= cfg.wdata;
				REG_PIXEL_MIN:  pixel_min_q  <= cfg.wdata;
				REG_PIXEL_MAX:  pixel_max_q  <= cfg.wdata;
				default: begin
				end
			endcase
		end
	end

	// Parser.
	rle8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_ready   (in_ch.ready),
		.data_byte  (in_ch.data_byte),
		.final_byte (in_ch.final_byte),
		.line_width (line_width_q),
		.push       (push),
		.push_cmd   (push_cmd),
		.queue_full (queue_full)
	);

	// Command queue.
	rle8_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (queue_full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (queue_empty)
	);

	// Sample scaler and result register.
	rle8_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_min    (pixel_min_q),
		.pixel_max    (pixel_max_q),
		.empty        (queue_empty),
		.pop_cmd      (pop_cmd),
		.pop          (pop),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.result_kind  (out_ch.result_kind),
		.pixel_value  (out_ch.pixel_value),
		.repeat_count (out_ch.repeat_count),
		.line_status  (out_ch.line_status),
		.end_of_line  (out_ch.end_of_line)
	);

endmodule

### verif/tb.sv
// Self-checking testbench for the 8-bit run-length scanline decoder.
// Drives compressed bytes, predicts every sample run and line status, and checks each result.
// Depends on rle8_pkg, the three channel interfaces and rle_scanline_decoder_8bit_top.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rle8_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 250;

	// Where the parser stands within the current line.
	typedef enum logic [2:0] {
		DEC_CODE,
		DEC_LITERAL,
		DEC_VALUE,
		DEC_ENDED,
		DEC_ERROR
	} dec_phase_t;

	// One result as it appears on the output channel.
	typedef struct packed {
		logic                kind;
		logic [BYTE_W-1:0]   value;
		logic [COUNT_W-1:0]  count;
		logic [STATUS_W-1:0] status;
		logic                eol;
	} pixel_result_t;

	logic clk;
	logic arst_n;

	rle8_in_if  in_ch ();
	rle8_out_if out_ch ();
	rle8_cfg_if cfg ();

	rle_scanline_decoder_8bit_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	// Register copies, as written through the configuration channel.
	logic [CFG_W-1:0] line_width_q = LINE_WIDTH_RST;
	logic [CFG_W-1:0] pix_min_q    = PIXEL_MIN_RST;
	logic [CFG_W-1:0] pix_max_q    = PIXEL_MAX_RST;

	// Line decoding state.
	dec_phase_t         dec_phase;
	logic [COUNT_W-1:0] lit_left;
	logic [COUNT_W-1:0] run_pending;
	logic [CFG_W-1:0]   px_left;
	line_status_t       err_code;

	pixel_result_t decoded_q[$];

	int tx_idle_pct;
	int rx_stall_pct;
	bit rx_hold_req;
	int rx_hold_left;
	int cycle_count;
	int mismatches;
	int n_bytes;
	int n_lines;
	int n_results;
	logic [7:0] status_seen;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Give up on a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d results outstanding", $time, decoded_q.size());
			$display("simulation failed");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off when one is requested.
	always @(negedge clk) begin
		if (rx_hold_req) begin
			rx_hold_left = HOLD_CYCLES;
			rx_hold_req = 1'b0;
		end
		if (rx_hold_left != 0) begin
			rx_hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Compare each result transfer against the oldest prediction.
	always @(posedge clk) begin
		pixel_result_t got;
		pixel_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = {out_ch.result_kind, out_ch.pixel_value, out_ch.repeat_count,
				out_ch.line_status, out_ch.end_of_line};
			n_results++;
			if (decoded_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result kind %h value %h count %h status %h eol %h",
					$time, got.kind, got.value, got.count, got.status, got.eol);
			end else begin
				want = decoded_q.pop_front();
				if (got !== want) begin
					mismatches++;
					$display("%0t: expected kind %h value %h count %h status %h eol %h",
						$time, want.kind, want.value, want.count, want.status, want.eol);
					$display("%0t:   actual kind %h value %h count %h status %h eol %h",
						$time, got.kind, got.value, got.count, got.status, got.eol);
				end
			end
		end
	end

	// Clamp a stored sample to the valid range and stretch it to 0..255.
	function automatic logic [BYTE_W-1:0] scaled_sample(input logic [BYTE_W-1:0] s);
		int unsigned v;
		int unsigned span;
		if (pix_min_q == 16'd0 && pix_max_q == FULL_SCALE)
			return s;
		if (pix_max_q <= pix_min_q)
			return '0;
		span = 32'(pix_max_q - pix_min_q);
		v = 32'(s);
		if (v < 32'(pix_min_q))
			v = 0;
		else if (v > 32'(pix_max_q))
			v = span;
		else
			v = v - 32'(pix_min_q);
		return BYTE_W'((v * 32'(FULL_SCALE)) / span);
	endfunction

	task automatic start_line();
		dec_phase = DEC_CODE;
		lit_left = '0;
		run_pending = '0;
		px_left = line_width_q;
		err_code = ST_OK;
	endtask

	// Advance the line state by one byte and queue the results it yields.
	task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic fin);
		logic [COUNT_W-1:0] cnt;
		line_status_t st;
		cnt = b[COUNT_W-1:0];
		case (dec_phase)
			DEC_CODE: begin
				if (cnt == 0) begin
					dec_phase = DEC_ENDED;
				end else if (b[7]) begin
					if (CFG_W'(cnt) > px_left) begin
						err_code = ST_LIT_OVERFLOW;
						dec_phase = DEC_ERROR;
					end else begin
						px_left = px_left - CFG_W'(cnt);
						lit_left = cnt;
						dec_phase = DEC_LITERAL;
					end
				end else begin
					if (CFG_W'(cnt) > px_left) begin
						err_code = ST_RUN_OVERFLOW;
						dec_phase = DEC_ERROR;
					end else begin
						run_pending = cnt;
						dec_phase = DEC_VALUE;
					end
				end
			end
			DEC_LITERAL: begin
				decoded_q.push_back({1'b0, scaled_sample(b), 7'd1, ST_OK, 1'b0});
				lit_left = lit_left - 1'b1;
				if (lit_left == 0)
					dec_phase = DEC_CODE;
			end
			DEC_VALUE: begin
				decoded_q.push_back({1'b0, scaled_sample(b), run_pending, ST_OK, 1'b0});
				px_left = (CFG_W'(run_pending) > px_left) ? '0 :
					px_left - CFG_W'(run_pending);
				run_pending = '0;
				dec_phase = DEC_CODE;
			end
			DEC_ENDED: begin
				err_code = (px_left != 0) ? ST_INCOMPLETE : ST_UNUSED_DATA;
				dec_phase = DEC_ERROR;
			end
			default: begin
			end
		endcase

		if (fin) begin
			if (dec_phase == DEC_ERROR)
				st = err_code;
			else if (dec_phase == DEC_LITERAL)
				st = ST_LIT_TRUNC;
			else if (dec_phase == DEC_VALUE)
				st = ST_RUN_NO_VALUE;
			else
				st = (px_left != 0) ? ST_INCOMPLETE : ST_OK;
			decoded_q.push_back({1'b1, 8'd0, 7'd0, st, 1'b1});
			status_seen[st] = 1'b1;
			n_lines++;
			start_line();
		end
	endtask

	// Offer one byte, with random idle cycles ahead of it, and wait for its transfer.
	task automatic push_byte(input logic [BYTE_W-1:0] b, input logic fin);
		@(negedge clk);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.final_byte <= fin;
		do @(posedge clk); while (!in_ch.ready);
		decode_byte(b, fin);
		n_bytes++;
	endtask

	// Send a whole compressed line; the last byte carries the final mark.
	task automatic push_line(input logic [BYTE_W-1:0] seq[$]);
		foreach (seq[i])
			push_byte(seq[i], i == seq.size() - 1);
	endtask

	// Stop offering bytes and wait until every predicted result has come out.
	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.wdata <= val;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			REG_LINE_WIDTH: line_width_q = val;
			REG_PIXEL_MIN:  pix_min_q = val;
			REG_PIXEL_MAX:  pix_max_q = val;
			default: begin
			end
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// New settings on an idle block, then an empty line so the width is loaded.
	task automatic retune(input logic [CFG_W-1:0] lw, input logic [CFG_W-1:0] pmin,
		input logic [CFG_W-1:0] pmax);
		settle();
		write_reg(REG_LINE_WIDTH, lw);
		write_reg(REG_PIXEL_MIN, pmin);
		write_reg(REG_PIXEL_MAX, pmax);
		push_byte(8'h00, 1'b1);
	endtask

	// Reset values: 512-pixel lines and unscaled samples.
	task automatic test_reset_defaults();
		push_line('{8'h82, 8'h00, 8'hff, 8'h7f, 8'haa, 8'h00});
	endtask

	// Short lines that end in each of the status codes.
	task automatic test_line_status();
		retune(16'd4, 16'd0, 16'd255);
		push_line('{8'h84, 8'h00, 8'h80, 8'h7f, 8'hff, 8'h00});
		// Literal too long: the error sticks through the rest of the line.
		push_line('{8'h85, 8'h12});
		push_line('{8'h83, 8'h10});
		push_line('{8'h05, 8'h00});
		push_line('{8'h04});
		// Data after the end code, once with pixels left and once with a full line.
		push_line('{8'h02, 8'h01, 8'h00, 8'h55});
		push_line('{8'h04, 8'h01, 8'h00, 8'h66});
		// A literal code with a zero count also ends the line.
		push_line('{8'h80});
		push_line('{8'h04, 8'h33});
	endtask

	// Clamping and rescaling, an empty sample range and a zero line width.
	task automatic test_rescale();
		retune(16'd8, 16'd16, 16'd200);
		push_line('{8'h84, 8'h00, 8'h10, 8'hc8, 8'hff, 8'h04, 8'h80});
		retune(16'd3, 16'd100, 16'd100);
		push_line('{8'h81, 8'h42, 8'h02, 8'h99});
		retune(16'd0, 16'd0, 16'd255);
		push_line('{8'h01, 8'h00});
		push_line('{8'h81});
		push_line('{8'h00, 8'h07});
	endtask

	// The receiver holds off while a long line streams in, so the input must stall.
	task automatic test_backpressure();
		logic [BYTE_W-1:0] seq[$];
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		retune(16'd100, 16'd0, 16'd255);
		seq.push_back(8'hb2);
		repeat (50) seq.push_back(BYTE_W'($urandom_range(255)));
		seq.push_back(8'h32);
		seq.push_back(8'h5a);
		seq.push_back(8'h00);
		rx_hold_req = 1'b1;
		push_line(seq);
		settle();
	endtask

	// Build a random line: mostly well formed, some broken, some pure noise.
	task automatic send_random_line();
		logic [BYTE_W-1:0] seq[$];
		int left;
		int cnt;
		int style;
		int pos;
		left = int'(px_left);
		style = $urandom_range(99);
		if (style >= 90) begin
			repeat ($urandom_range(1, 8)) seq.push_back(BYTE_W'($urandom_range(255)));
		end else begin
			for (int k = 0; k < 12 && left > 0; k++) begin
				cnt = $urandom_range(1, ($urandom_range(7) == 0) ? 127 : 6);
				if (cnt > left)
					cnt = left;
				if ($urandom_range(1)) begin
					seq.push_back(BYTE_W'(8'h80 | cnt));
					repeat (cnt) seq.push_back(BYTE_W'($urandom_range(255)));
				end else begin
					seq.push_back(BYTE_W'(cnt));
					seq.push_back(BYTE_W'($urandom_range(255)));
				end
				left -= cnt;
			end
			if ($urandom_range(3) != 0)
				seq.push_back($urandom_range(1) ? 8'h80 : 8'h00);
			if (seq.size() == 0)
				seq.push_back(8'h00);
			// Broken lines: one byte replaced, the line cut short, or junk appended.
			if (style >= 75) begin
				case ($urandom_range(2))
					0: begin
						pos = $urandom_range(seq.size() - 1);
						seq[pos] = BYTE_W'($urandom_range(255));
					end
					1: begin
						pos = $urandom_range(1, seq.size());
						while (seq.size() > pos)
							void'(seq.pop_back());
					end
					default: begin
						repeat ($urandom_range(1, 3)) seq.push_back(BYTE_W'($urandom_range(255)));
					end
				endcase
			end
		end
		push_line(seq);
	endtask

	// Random lines under changing settings and four idle patterns.
	task automatic test_random();
		int tx_pct[4] = '{0, 47, 0, 25};
		int rx_pct[4] = '{0, 0, 47, 25};
		int phase_start;
		int next_retune;
		logic [CFG_W-1:0] lw;
		logic [CFG_W-1:0] pmin;
		logic [CFG_W-1:0] pmax;
		for (int ph = 0; ph < 4; ph++) begin
			tx_idle_pct = tx_pct[ph];
			rx_stall_pct = rx_pct[ph];
			phase_start = n_bytes;
			next_retune = n_bytes;
			while (n_bytes - phase_start < 160) begin
				if (n_bytes >= next_retune) begin
					case ($urandom_range(7))
						0: lw = 16'd0;
						1: lw = 16'd65535;
						2: lw = 16'd1;
						3: lw = CFG_W'($urandom_range(65535));
						default: lw = CFG_W'($urandom_range(1, 48));
					endcase
					case ($urandom_range(7))
						0, 1: begin
							pmin = 16'd0;
							pmax = FULL_SCALE;
						end
						2: begin
							pmin = CFG_W'($urandom_range(255));
							pmax = pmin + CFG_W'($urandom_range(1, 300));
						end
						3: begin
							pmin = 16'd0;
							pmax = 16'd65535;
						end
						4: begin
							pmin = 16'd0;
							pmax = CFG_W'($urandom_range(1, 255));
						end
						5: begin
							pmin = CFG_W'($urandom_range(255));
							pmax = CFG_W'($urandom_range(pmin));
						end
						6: begin
							pmin = 16'd65535;
							pmax = 16'd65535;
						end
						default: begin
							pmin = CFG_W'($urandom_range(65535));
							pmax = CFG_W'($urandom_range(65535));
						end
					endcase
					retune(lw, pmin, pmax);
					next_retune = n_bytes + 60;
				end
				send_random_line();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.final_byte = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_LINE_WIDTH;
		cfg.wdata = '0;
		out_ch.ready = 1'b0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		rx_hold_req = 1'b0;
		rx_hold_left = 0;
		status_seen = '0;
		start_line();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_line_status();
		test_rescale();
		test_backpressure();
		test_random();
		settle();

		$display("Decoded %0d bytes in %0d lines; %0d results checked, %0d mismatches.",
			n_bytes, n_lines, n_results, mismatches);
		$display("Line status codes reported (bit per code): %b", status_seen);
		if (mismatches == 0 && decoded_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

### sim.f
rtl/rle8_pkg.sv
rtl/rle8_in_if.sv
rtl/rle8_out_if.sv
rtl/rle8_cfg_if.sv
rtl/rle8_front.sv
rtl/rle8_fifo.sv
rtl/rle8_back.sv
rtl/rle8_scanline_decoder_8bit_top.sv
verif/tb.sv
